>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
// all of them sample on clk and are held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// condition in this cycle implies a consequence in the same cycle
`define ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// condition in this cycle implies a consequence in the next cycle
`define ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/dksht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dksht_pkg
// types and constants of the dual key session hash table
// ----------------------------------------------------------------------------
package dksht_pkg;

	// default sizes
	localparam int DEF_MAX_SESSIONS = 256;
	localparam int DEF_INDEX_SLOTS  = 1024;

	// mixing function constants
	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int          MIX_SHIFT_A = 13;
	localparam int          MIX_SHIFT_B = 15;

	// descriptor value left in a removed slot
	localparam logic [15:0] DESC_TOMB = 16'hffff;

	// slot memory word: active, ip, port, descriptor
	localparam int SLOT_W = 1 + 32 + 16 + 16;

	typedef enum logic [1:0] {
		MODE_INSERT    = 2'd0,
		MODE_FIND_ADDR = 2'd1,
		MODE_FIND_DESC = 2'd2,
		MODE_REMOVE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NOTFOUND = 2'd1,
		STATUS_FULL     = 2'd2,
		STATUS_INACTIVE = 2'd3
	} status_t;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] client_ip;
		logic [15:0] client_port;
		logic [15:0] relay_descriptor;
		logic [7:0]  slot_number;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  result_slot;
		logic [31:0] found_ip;
		logic [15:0] found_port;
		logic [15:0] found_descriptor;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_MIX0,
		ST_MIX1,
		ST_MIX2,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_PUT_RD,
		ST_PUT_CHK,
		ST_FIND_RD,
		ST_FIND_IDX,
		ST_FIND_SLOT,
		ST_RM_RD,
		ST_RM_CHK,
		ST_ICLR,
		ST_RB_RD,
		ST_RB_CHK,
		ST_DONE
	} state_t;

endpackage

>>> rtl/dksht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dksht_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module dksht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/dksht_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dksht_mix
// two stage pipelined murmur style 32-bit mix, hash folded from the second register
// ----------------------------------------------------------------------------
module dksht_mix (
	input  logic        clk,
	input  logic [31:0] key,
	output logic [31:0] hash
);

	logic [31:0] mix_s1;
	logic [31:0] mix_s2;
	logic [31:0] prod;

	// multiply by the mixing constant, low word kept
	assign prod = mix_s1 * dksht_pkg::MIX_MUL;

	always_ff @(posedge clk) begin
		mix_s1 <= key ^ (key >> dksht_pkg::MIX_SHIFT_A);
		mix_s2 <= prod;
	end

	// final fold
	assign hash = mix_s2 ^ (mix_s2 >> dksht_pkg::MIX_SHIFT_B);

endmodule

>>> rtl/dual_key_session_hash_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_key_session_hash_table_unit
// session slot pool with address and descriptor hash indexes
// ----------------------------------------------------------------------------
// requests arrive on req (valid/ready) and each gives one response on rsp.
// modes: insert into the lowest free slot, find by address, find by
// descriptor, remove slot. one request is worked on at a time; req_ready is
// high only while the block is idle.
// sequencing: a hash passes through the pipelined mix in MIX0, MIX1, MIX2.
// a find reads the index, then the slot, on each probe. an insert reads and
// checks each slot scanned for a free one, then probes each index table.
// a remove sweeps both index tables and then rebuilds them, reading each
// slot and taking a hash and the probes per active slot. the slot memory
// and index memory have one read port each.
// after reset a clearing pass zeroes every slot and index entry before the
// first request is taken.
// the response sits in an output register; while rsp_ready is low the block
// still takes the next request and holds its result until the register frees.
// ----------------------------------------------------------------------------
module dual_key_session_hash_table_unit #(
	parameter int MAX_SESSIONS = dksht_pkg::DEF_MAX_SESSIONS,
	parameter int INDEX_SLOTS  = dksht_pkg::DEF_INDEX_SLOTS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  dksht_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output dksht_pkg::rsp_t   rsp
);

	`include "assert_macros.svh"

	localparam int SW    = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
	localparam int IW    = $clog2(INDEX_SLOTS);
	localparam int XW    = IW + 1;
	localparam int EW    = SW + 1;
	localparam int LW    = $clog2(MAX_SESSIONS + 1);
	localparam int PW    = IW + 1;
	localparam int IDX_N = 2 * INDEX_SLOTS;
	localparam int CLR_N = (IDX_N > MAX_SESSIONS) ? IDX_N : MAX_SESSIONS;
	localparam int CW    = $clog2(CLR_N);
	localparam int DW    = dksht_pkg::SLOT_W;

	dksht_pkg::state_t state_q, state_d;

	// control registers
	logic [CW-1:0] clr_q;
	logic [LW-1:0] live_q;
	logic [SW-1:0] scan_q;
	logic [SW-1:0] rb_q;
	logic [IW-1:0] pos_q;
	logic [PW-1:0] probe_q;
	logic          tbl_q;
	logic          rsp_valid_q;

	// payload registers
	dksht_pkg::mode_t mode_q;
	logic [31:0]      key_ip_q;
	logic [15:0]      key_port_q;
	logic [15:0]      key_desc_q;
	logic [7:0]       sn_q;
	logic [SW-1:0]    slot_q;
	logic [IW-1:0]    hash_d_q;
	dksht_pkg::rsp_t  res_q;
	dksht_pkg::rsp_t  rsp_q;

	// memory ports
	logic          slot_we;
	logic [SW-1:0] slot_waddr;
	logic [DW-1:0] slot_wdata;
	logic [SW-1:0] slot_raddr;
	logic [DW-1:0] slot_rdata;
	logic          idx_we;
	logic [XW-1:0] idx_waddr;
	logic [EW-1:0] idx_wdata;
	logic [XW-1:0] idx_raddr;
	logic [EW-1:0] idx_rdata;

	// hashes
	logic [31:0] hash_a;
	logic [31:0] hash_d;

	// decoded read data and conditions
	logic          s_act;
	logic [31:0]   s_ip;
	logic [15:0]   s_port;
	logic [15:0]   s_desc;
	logic          i_vld;
	logic [SW-1:0] i_slot;
	logic          key_match;
	logic          probe_last;
	logic          put_done;
	logic          rb_last;
	logic          pool_full;
	logic          sn_ok;
	logic          out_free;
	logic          accept;

	// response of a refused or missed request, data fields zero
	function automatic dksht_pkg::rsp_t fail_rsp(input dksht_pkg::status_t st);
		dksht_pkg::rsp_t r;
		r        = '0;
		r.status = st;
		return r;
	endfunction

	// storage
	dksht_ram #(.WIDTH(DW), .DEPTH(MAX_SESSIONS), .AW(SW)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	dksht_ram #(.WIDTH(EW), .DEPTH(IDX_N), .AW(XW)) u_idx_ram (
		.clk   (clk),
		.we    (idx_we),
		.waddr (idx_waddr),
		.wdata (idx_wdata),
		.raddr (idx_raddr),
		.rdata (idx_rdata)
	);

	dksht_mix u_mix_addr (
		.clk  (clk),
		.key  (key_ip_q ^ {key_port_q, 16'h0000}),
		.hash (hash_a)
	);

	dksht_mix u_mix_desc (
		.clk  (clk),
		.key  ({16'h0000, key_desc_q}),
		.hash (hash_d)
	);

	// field decode and shared conditions
	assign s_act      = slot_rdata[DW-1];
	assign s_ip       = slot_rdata[63:32];
	assign s_port     = slot_rdata[31:16];
	assign s_desc     = slot_rdata[15:0];
	assign i_vld      = idx_rdata[SW];
	assign i_slot     = idx_rdata[SW-1:0];
	assign key_match  = tbl_q ? (s_desc == key_desc_q)
	                          : (s_ip == key_ip_q && s_port == key_port_q);
	assign probe_last = (probe_q == PW'(INDEX_SLOTS - 1));
	assign put_done   = !i_vld || probe_last;
	assign rb_last    = (rb_q == SW'(MAX_SESSIONS - 1));
	assign pool_full  = (live_q >= LW'(MAX_SESSIONS));
	assign sn_ok      = (32'(sn_q) < 32'(MAX_SESSIONS));
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign req_ready  = (state_q == dksht_pkg::ST_IDLE);
	assign accept     = req_valid && req_ready;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dksht_pkg::ST_INIT: begin
				if (clr_q == CW'(CLR_N - 1)) state_d = dksht_pkg::ST_IDLE;
			end
			dksht_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = (req.mode == dksht_pkg::MODE_REMOVE) ?
					          dksht_pkg::ST_RM_RD : dksht_pkg::ST_MIX0;
				end
			end
			dksht_pkg::ST_MIX0: state_d = dksht_pkg::ST_MIX1;
			dksht_pkg::ST_MIX1: state_d = dksht_pkg::ST_MIX2;
			dksht_pkg::ST_MIX2: begin
				case (mode_q)
					dksht_pkg::MODE_INSERT:
						state_d = pool_full ? dksht_pkg::ST_DONE : dksht_pkg::ST_SCAN_RD;
					dksht_pkg::MODE_REMOVE: state_d = dksht_pkg::ST_PUT_RD;
					default: state_d = dksht_pkg::ST_FIND_RD;
				endcase
			end
			dksht_pkg::ST_SCAN_RD: state_d = dksht_pkg::ST_SCAN_CHK;
			dksht_pkg::ST_SCAN_CHK: begin
				state_d = s_act ? dksht_pkg::ST_SCAN_RD : dksht_pkg::ST_PUT_RD;
			end
			dksht_pkg::ST_PUT_RD: state_d = dksht_pkg::ST_PUT_CHK;
			dksht_pkg::ST_PUT_CHK: begin
				if (!put_done || !tbl_q) begin
					state_d = dksht_pkg::ST_PUT_RD;
				end else if (mode_q == dksht_pkg::MODE_REMOVE && !rb_last) begin
					state_d = dksht_pkg::ST_RB_RD;
				end else begin
					state_d = dksht_pkg::ST_DONE;
				end
			end
			dksht_pkg::ST_FIND_RD: state_d = dksht_pkg::ST_FIND_IDX;
			dksht_pkg::ST_FIND_IDX: begin
				state_d = i_vld ? dksht_pkg::ST_FIND_SLOT : dksht_pkg::ST_DONE;
			end
			dksht_pkg::ST_FIND_SLOT: begin
				if ((s_act && key_match) || probe_last) state_d = dksht_pkg::ST_DONE;
				else state_d = dksht_pkg::ST_FIND_RD;
			end
			dksht_pkg::ST_RM_RD: begin
				state_d = sn_ok ? dksht_pkg::ST_RM_CHK : dksht_pkg::ST_DONE;
			end
			dksht_pkg::ST_RM_CHK: begin
				state_d = s_act ? dksht_pkg::ST_ICLR : dksht_pkg::ST_DONE;
			end
			dksht_pkg::ST_ICLR: begin
				if (clr_q == CW'(IDX_N - 1)) state_d = dksht_pkg::ST_RB_RD;
			end
			dksht_pkg::ST_RB_RD: state_d = dksht_pkg::ST_RB_CHK;
			dksht_pkg::ST_RB_CHK: begin
				if (s_act) state_d = dksht_pkg::ST_MIX0;
				else if (rb_last) state_d = dksht_pkg::ST_DONE;
				else state_d = dksht_pkg::ST_RB_RD;
			end
			dksht_pkg::ST_DONE: begin
				if (out_free) state_d = dksht_pkg::ST_IDLE;
			end
			default: state_d = dksht_pkg::ST_INIT;
		endcase
	end

	// memory port drive
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = scan_q;
		slot_wdata = '0;
		slot_raddr = scan_q;
		idx_we     = 1'b0;
		idx_waddr  = {tbl_q, pos_q};
		idx_wdata  = '0;
		idx_raddr  = {tbl_q, pos_q};
		case (state_q)
			dksht_pkg::ST_INIT: begin
				slot_we    = (32'(clr_q) < 32'(MAX_SESSIONS));
				slot_waddr = SW'(clr_q);
				idx_we     = (32'(clr_q) < 32'(IDX_N));
				idx_waddr  = XW'(clr_q);
			end
			dksht_pkg::ST_ICLR: begin
				idx_we    = 1'b1;
				idx_waddr = XW'(clr_q);
			end
			dksht_pkg::ST_SCAN_CHK: begin
				slot_we    = !s_act;
				slot_wdata = {1'b1, key_ip_q, key_port_q, key_desc_q};
			end
			dksht_pkg::ST_PUT_CHK: begin
				idx_we    = !i_vld;
				idx_wdata = {1'b1, slot_q};
			end
			dksht_pkg::ST_FIND_IDX: slot_raddr = i_slot;
			dksht_pkg::ST_RM_RD: slot_raddr = SW'(sn_q);
			dksht_pkg::ST_RM_CHK: begin
				slot_we    = s_act;
				slot_waddr = SW'(sn_q);
				slot_wdata = {1'b0, s_ip, s_port, dksht_pkg::DESC_TOMB};
			end
			dksht_pkg::ST_RB_RD: slot_raddr = rb_q;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dksht_pkg::ST_INIT;
			clr_q       <= '0;
			live_q      <= '0;
			scan_q      <= '0;
			rb_q        <= '0;
			pos_q       <= '0;
			probe_q     <= '0;
			tbl_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// response register handshake
			if (state_q == dksht_pkg::ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				dksht_pkg::ST_INIT: clr_q <= clr_q + CW'(1);
				dksht_pkg::ST_ICLR: clr_q <= clr_q + CW'(1);
				dksht_pkg::ST_MIX2: begin
					tbl_q   <= (mode_q == dksht_pkg::MODE_FIND_DESC);
					pos_q   <= (mode_q == dksht_pkg::MODE_FIND_DESC) ?
					           hash_d[IW-1:0] : hash_a[IW-1:0];
					probe_q <= '0;
					scan_q  <= '0;
				end
				dksht_pkg::ST_SCAN_CHK: begin
					if (s_act) scan_q <= scan_q + SW'(1);
					else live_q <= live_q + LW'(1);
				end
				dksht_pkg::ST_PUT_CHK: begin
					if (!put_done) begin
						pos_q   <= pos_q + IW'(1);
						probe_q <= probe_q + PW'(1);
					end else if (!tbl_q) begin
						tbl_q   <= 1'b1;
						pos_q   <= hash_d_q;
						probe_q <= '0;
					end else if (mode_q == dksht_pkg::MODE_REMOVE && !rb_last) begin
						rb_q <= rb_q + SW'(1);
					end
				end
				dksht_pkg::ST_FIND_SLOT: begin
					if (!(s_act && key_match) && !probe_last) begin
						pos_q   <= pos_q + IW'(1);
						probe_q <= probe_q + PW'(1);
					end
				end
				dksht_pkg::ST_RM_CHK: begin
					if (s_act) begin
						if (live_q != '0) live_q <= live_q - LW'(1);
						clr_q <= '0;
						rb_q  <= '0;
					end
				end
				dksht_pkg::ST_RB_CHK: begin
					if (!s_act && !rb_last) rb_q <= rb_q + SW'(1);
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			dksht_pkg::ST_IDLE: begin
				if (accept) begin
					mode_q     <= req.mode;
					key_ip_q   <= req.client_ip;
					key_port_q <= req.client_port;
					key_desc_q <= req.relay_descriptor;
					sn_q       <= req.slot_number;
				end
			end
			dksht_pkg::ST_MIX2: begin
				hash_d_q <= hash_d[IW-1:0];
				if (mode_q == dksht_pkg::MODE_INSERT && pool_full) begin
					res_q <= fail_rsp(dksht_pkg::STATUS_FULL);
				end
			end
			dksht_pkg::ST_SCAN_CHK: begin
				if (!s_act) begin
					slot_q                 <= scan_q;
					res_q.status           <= dksht_pkg::STATUS_OK;
					res_q.result_slot      <= 8'(scan_q);
					res_q.found_ip         <= key_ip_q;
					res_q.found_port       <= key_port_q;
					res_q.found_descriptor <= key_desc_q;
				end
			end
			dksht_pkg::ST_FIND_IDX: begin
				if (i_vld) begin
					slot_q <= i_slot;
				end else begin
					res_q <= fail_rsp(dksht_pkg::STATUS_NOTFOUND);
				end
			end
			dksht_pkg::ST_FIND_SLOT: begin
				if (s_act && key_match) begin
					res_q.status           <= dksht_pkg::STATUS_OK;
					res_q.result_slot      <= 8'(slot_q);
					res_q.found_ip         <= s_ip;
					res_q.found_port       <= s_port;
					res_q.found_descriptor <= s_desc;
				end else if (probe_last) begin
					res_q <= fail_rsp(dksht_pkg::STATUS_NOTFOUND);
				end
			end
			dksht_pkg::ST_RM_RD: begin
				if (!sn_ok) begin
					res_q <= fail_rsp(dksht_pkg::STATUS_INACTIVE);
				end
			end
			dksht_pkg::ST_RM_CHK: begin
				if (s_act) begin
					res_q.status           <= dksht_pkg::STATUS_OK;
					res_q.result_slot      <= sn_q;
					res_q.found_ip         <= s_ip;
					res_q.found_port       <= s_port;
					res_q.found_descriptor <= s_desc;
				end else begin
					res_q <= fail_rsp(dksht_pkg::STATUS_INACTIVE);
				end
			end
			dksht_pkg::ST_RB_CHK: begin
				if (s_act) begin
					key_ip_q   <= s_ip;
					key_port_q <= s_port;
					key_desc_q <= s_desc;
					slot_q     <= rb_q;
				end
			end
			dksht_pkg::ST_DONE: begin
				if (out_free) rsp_q <= res_q;
			end
			default: ;
		endcase
	end

	// checks
	`ASSERT_ALWAYS(a_live_bound, live_q <= LW'(MAX_SESSIONS), "live count above pool size")
	`ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request taken while busy")
	`ASSERT_IMPL(a_scan_range, state_q == dksht_pkg::ST_SCAN_CHK, 32'(scan_q) < 32'(MAX_SESSIONS), "free slot scan overran")
	`ASSERT_IMPL(a_fail_zero, rsp_valid && rsp.status != dksht_pkg::STATUS_OK, rsp.result_slot == 8'h00 && rsp.found_ip == 32'h0, "failed response carries data")

endmodule
